// ===== rtl/core/cst_pkg.sv =====
// Shared types, constants and helpers for the counting semaphore table.
package cst_pkg;

	// Table geometry
	localparam int NUM_SEMS = 16;
	localparam int IDX_W    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int USED_W   = $clog2(NUM_SEMS + 1);

	// Field widths fixed by the interface
	localparam int REQ_W    = 2;
	localparam int SEMID_W  = 8;
	localparam int COUNT_W  = 16;
	localparam int STATUS_W = 2;
	localparam int ID_W     = 4;
	localparam int INUSE_W  = 5;

	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [USED_W-1:0]         used_t;
	typedef logic signed [COUNT_W-1:0] count_t;

	localparam count_t COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
	localparam count_t COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};

	typedef enum logic [REQ_W-1:0] {
		REQ_CREATE = 2'd0,
		REQ_FREE   = 2'd1,
		REQ_P      = 2'd2,
		REQ_V      = 2'd3
	} req_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_BAD_ARG = 2'd1,
		ST_NO_FREE = 2'd2
	} status_e;

	// Commands from the request logic to the allocation bitmap
	typedef struct packed {
		logic set;   // mark the lowest free entry allocated
		logic clr;   // clear the entry at idx
		idx_t idx;   // entry looked up and cleared
	} alloc_cmd_t;

	// Status from the allocation bitmap
	typedef struct packed {
		logic  found;     // some entry is free
		idx_t  free_idx;  // lowest free entry
		logic  is_alloc;  // entry at cmd.idx is allocated
		used_t used;      // allocated entries before this request
	} alloc_sts_t;

	// Entry index to the id field, masked to the field width
	function automatic logic [ID_W-1:0] id_field(input idx_t idx);
		logic [IDX_W+ID_W-1:0] w;
		w = {{ID_W{1'b0}}, idx};
		return w[ID_W-1:0];
	endfunction

	// Allocated count to the in-use field, masked to the field width
	function automatic logic [INUSE_W-1:0] inuse_field(input used_t u);
		logic [USED_W+INUSE_W-1:0] w;
		w = {{INUSE_W{1'b0}}, u};
		return w[INUSE_W-1:0];
	endfunction

endpackage

// ===== rtl/core/cst_if.sv =====
// Request and response channel interfaces of the semaphore table.
interface cst_req_if;
	import cst_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [REQ_W-1:0]          req_type;
	logic signed [SEMID_W-1:0] sem_id;
	logic signed [COUNT_W-1:0] initial_count;

	modport source (output valid, req_type, sem_id, initial_count, input ready);
	modport sink   (input valid, req_type, sem_id, initial_count, output ready);
endinterface

interface cst_rsp_if;
	import cst_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     alloc_id;
	logic                must_wait;
	logic                wake_one;
	logic [INUSE_W-1:0]  in_use;

	modport source (output valid, status, alloc_id, must_wait, wake_one, in_use, input ready);
	modport sink   (input valid, status, alloc_id, must_wait, wake_one, in_use, output ready);
endinterface

// ===== rtl/core/cst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/cst_alloc.sv =====
// Allocation bitmap, lowest-free search and allocated-entry counter.
module cst_alloc (
	input  logic                clk,
	input  logic                arst_n,
	input  cst_pkg::alloc_cmd_t cmd,
	output cst_pkg::alloc_sts_t sts
);
	import cst_pkg::*;

	logic [NUM_SEMS-1:0] alloc_q;
	used_t               used_q;
	logic                found;
	idx_t                free_idx;

	// Lowest free entry: scan down so the lowest index wins
	always_comb begin
		found    = 1'b0;
		free_idx = '0;
		for (int i = NUM_SEMS - 1; i >= 0; i--) begin
			if (!alloc_q[i]) begin
				found    = 1'b1;
				free_idx = idx_t'(i);
			end
		end
	end

	assign sts.found    = found;
	assign sts.free_idx = free_idx;
	assign sts.is_alloc = alloc_q[cmd.idx];
	assign sts.used     = used_q;

	// Bitmap and count update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q <= '0;
			used_q  <= '0;
		end else begin
			if (cmd.set && found) begin
				alloc_q[free_idx] <= 1'b1;
				used_q            <= used_q + used_t'(1);
			end else if (cmd.clr && alloc_q[cmd.idx]) begin
				alloc_q[cmd.idx] <= 1'b0;
				used_q           <= used_q - used_t'(1);
			end
		end
	end
endmodule

// ===== rtl/core/counting_semaphore_table.sv =====
// Counting semaphore table: top level with count RAM and request sequencing.
// Each request word is a read-modify-write: the count of the addressed entry is read from
// a RAM with registered read data in the accept cycle, and the next cycle modifies it, writes
// it back and loads the response register; no new request is taken while one is pending.
// A response that is not taken holds off the
// next request, which can be accepted in the same cycle the response is taken.
// Allocated bits and per-entry valid bits sit in flip-flops and clear at reset, so
// the table is usable at once.
module counting_semaphore_table (
	input  logic          clk,
	input  logic          arst_n,
	cst_req_if.sink       req,
	cst_rsp_if.source     rsp
);
	import cst_pkg::*;

	// Stage 1 request registers
	logic   pend_q;
	req_e   req_type_s1;
	idx_t   idx_s1;
	logic   bad_s1;
	count_t init_s1;

	// Count RAM and its per-entry valid bits
	logic [NUM_SEMS-1:0] vld_q;
	logic                ram_we;
	idx_t                ram_waddr;
	count_t              ram_wdata;
	logic [COUNT_W-1:0]  ram_rdata;
	count_t              cur_cnt;

	// Allocation bitmap
	alloc_cmd_t acmd;
	alloc_sts_t asts;

	// Response register
	logic                out_valid_q;
	status_e             status_q;
	logic [ID_W-1:0]     alloc_id_q;
	logic                must_wait_q;
	logic                wake_one_q;
	logic [INUSE_W-1:0]  in_use_q;

	// Next response values
	status_e             status_d;
	logic [ID_W-1:0]     alloc_id_d;
	logic                must_wait_d;
	logic                wake_one_d;
	used_t               used_d;
	count_t              new_cnt;

	logic accept;
	logic bad_id;

	assign req.ready = !pend_q && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	// Index out of range: negative or beyond the table
	assign bad_id = req.sem_id[SEMID_W-1] ||
		({1'b0, req.sem_id} >= (SEMID_W+1)'(NUM_SEMS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req_e'(req.req_type);
			idx_s1      <= req.sem_id[IDX_W-1:0];
			bad_s1      <= bad_id;
			init_s1     <= req.initial_count;
		end
	end

	cst_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (NUM_SEMS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (req.sem_id[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// Never-written entries read as zero
	assign cur_cnt = (!bad_s1 && vld_q[idx_s1]) ? count_t'(ram_rdata) : '0;

	cst_alloc u_alloc (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (acmd),
		.sts    (asts)
	);

	// Modify step of the read-modify-write
	always_comb begin
		acmd        = '{set: 1'b0, clr: 1'b0, idx: idx_s1};
		ram_we      = 1'b0;
		ram_waddr   = idx_s1;
		ram_wdata   = '0;
		status_d    = ST_OK;
		alloc_id_d  = '0;
		must_wait_d = 1'b0;
		wake_one_d  = 1'b0;
		used_d      = asts.used;
		new_cnt     = cur_cnt;
		unique case (req_type_s1)
			REQ_CREATE: begin
				if (init_s1 <= 0) begin
					status_d = ST_BAD_ARG;
				end else if (!asts.found) begin
					status_d = ST_NO_FREE;
				end else begin
					acmd.set   = pend_q;
					ram_we     = pend_q;
					ram_waddr  = asts.free_idx;
					ram_wdata  = init_s1;
					alloc_id_d = id_field(asts.free_idx);
					used_d     = asts.used + used_t'(1);
				end
			end
			REQ_FREE: begin
				if (bad_s1) begin
					status_d = ST_BAD_ARG;
				end else if (asts.is_alloc) begin
					acmd.clr  = pend_q;
					ram_we    = pend_q;
					ram_wdata = '0;
					used_d    = asts.used - used_t'(1);
				end
			end
			REQ_P: begin
				if (bad_s1) begin
					status_d = ST_BAD_ARG;
				end else begin
					if (cur_cnt != COUNT_MIN) begin
						new_cnt = cur_cnt - count_t'(1);
					end
					ram_we      = pend_q;
					ram_wdata   = new_cnt;
					must_wait_d = new_cnt < 0;
				end
			end
			REQ_V: begin
				if (bad_s1) begin
					status_d = ST_BAD_ARG;
				end else begin
					if (cur_cnt != COUNT_MAX) begin
						new_cnt = cur_cnt + count_t'(1);
					end
					ram_we     = pend_q;
					ram_wdata  = new_cnt;
					wake_one_d = new_cnt <= 0;
				end
			end
			default: begin
				status_d = ST_BAD_ARG;
			end
		endcase
	end

	// Entry valid bits: set on any count write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ram_we) begin
			vld_q[ram_waddr] <= 1'b1;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_q) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			status_q    <= status_d;
			alloc_id_q  <= alloc_id_d;
			must_wait_q <= must_wait_d;
			wake_one_q  <= wake_one_d;
			in_use_q    <= inuse_field(used_d);
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.alloc_id  = alloc_id_q;
	assign rsp.must_wait = must_wait_q;
	assign rsp.wake_one  = wake_one_q;
	assign rsp.in_use    = in_use_q;
endmodule

// ===== rtl/core/cst_checker.sv =====
// Port-level checks for the counting semaphore table, bound to the top level.
module cst_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [cst_pkg::STATUS_W-1:0] rsp_status,
	input logic [cst_pkg::ID_W-1:0]     rsp_alloc_id,
	input logic                         rsp_must_wait,
	input logic                         rsp_wake_one
);
	import cst_pkg::*;

	// A response stays offered until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before it was taken");

	// Every accepted request has its response once the pending step loads the response register
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> ##2 rsp_valid)
		else $error("no response after an accepted request");

	// Status is a defined code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_BAD_ARG ||
			rsp_status == ST_NO_FREE))
		else $error("undefined status code");

	// A failed request carries no side results
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |->
			rsp_alloc_id == '0 && !rsp_must_wait && !rsp_wake_one)
		else $error("failed request reports a side result");

	// A response never asks to block and to wake at once
	a_wait_wake: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_must_wait && rsp_wake_one))
		else $error("must_wait and wake_one both set");
endmodule

bind counting_semaphore_table cst_checker u_cst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_alloc_id  (rsp.alloc_id),
	.rsp_must_wait (rsp.must_wait),
	.rsp_wake_one  (rsp.wake_one)
);
